/* rtl/pfde_pkg.sv */
// Shared types and constants for the page framebuffer draw engine.
// Used by the control unit and the top level; no dependencies.
package pfde_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int ROWS_DEF    = 64;

  typedef enum logic [2:0] {
    CMD_SET_DOT     = 3'd0,
    CMD_FILL_RECT   = 3'd1,
    CMD_INVERT_RECT = 3'd2,
    CMD_WRITE_BYTE  = 3'd3,
    CMD_READ_BYTE   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_CLR,
    OP_SET,
    OP_FLIP,
    OP_OR,
    OP_REPL,
    OP_READ,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       rvalid;
  } res_t;

endpackage

/* rtl/pfde_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pfde_ctrl.sv */
// Command sequencer: clears the frame store, walks the bytes a request touches
// and does the read-modify-write of each; a read request only reads. Depends on pfde_pkg.
module pfde_ctrl #(
  parameter int COLUMNS = pfde_pkg::COLUMNS_DEF,
  parameter int ROWS    = pfde_pkg::ROWS_DEF,
  parameter int CW      = $clog2(COLUMNS),
  parameter int PAGES   = (ROWS + 7) / 8,
  parameter int PW      = (PAGES > 1) ? $clog2(PAGES) : 1,
  parameter int AW      = CW + PW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           cmd_i,
  input  logic [7:0]           x_i,
  input  logic [7:0]           y_i,
  input  logic [7:0]           width_i,
  input  logic [7:0]           height_i,
  input  logic                 color_i,
  input  logic [7:0]           data_i,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_addr_o,
  output logic [7:0]           mem_wdata_o,
  input  logic [7:0]           mem_rdata_i,
  input  logic                 res_ready_i,
  output pfde_pkg::res_t       res_o
);
  import pfde_pkg::*;

  localparam logic [8:0] ColLim   = 9'(COLUMNS);
  localparam logic [8:0] RowLim   = 9'(ROWS);
  localparam logic [7:0] LastMask = ((ROWS % 8) == 0) ? 8'hFF : 8'((1 << (ROWS % 8)) - 1);
  localparam logic [PW-1:0] PageMax = PW'(PAGES - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  op_e           op_q, op_d;
  logic [CW-1:0] col_q, col_d, col_first_q, col_first_d, col_last_q, col_last_d;
  logic [PW-1:0] page_q, page_d, page_first_q, page_first_d, page_last_q, page_last_d;
  logic [2:0]    off_q, off_d, lrow_q, lrow_d;
  logic [7:0]    data_q, data_d, rd_q, rd_d;
  logic          second_q, second_d;

  logic [CW-1:0] in_col;
  logic [7:0]    in_row;
  logic [7:0]    eff_w, eff_h;
  logic [8:0]    sum_c, sum_r;
  logic [7:0]    last_row;
  op_e           in_op;
  logic          is_rect;
  logic [2:0]    lo, hi;
  logic [7:0]    rect_mask, or_mask, new_byte, page_mask;
  logic          done_byte;

  always_comb begin
    in_col = ({1'b0, x_i} >= ColLim) ? '0 : x_i[CW-1:0];
    in_row = ({1'b0, y_i} >= RowLim) ? 8'd0 : y_i;
    is_rect = (cmd_i == CMD_FILL_RECT) || (cmd_i == CMD_INVERT_RECT);
    eff_w = is_rect ? width_i : 8'd0;
    eff_h = is_rect ? height_i : 8'd0;
    sum_c = {1'b0, 8'(in_col)} + {1'b0, eff_w};
    sum_r = {1'b0, in_row} + {1'b0, eff_h};
    last_row = (sum_r >= RowLim) ? 8'(ROWS - 1) : sum_r[7:0];
    unique case (cmd_i)
      CMD_SET_DOT:     in_op = color_i ? OP_SET : OP_CLR;
      CMD_FILL_RECT:   in_op = color_i ? OP_SET : OP_CLR;
      CMD_INVERT_RECT: in_op = OP_FLIP;
      CMD_WRITE_BYTE:  in_op = (in_row[2:0] == 3'd0) ? OP_REPL : OP_OR;
      CMD_READ_BYTE:   in_op = OP_READ;
      default:         in_op = OP_NONE;
    endcase
  end

  always_comb begin
    lo = (page_q == page_first_q) ? off_q : 3'd0;
    hi = (page_q == page_last_q) ? lrow_q : 3'd7;
    rect_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    or_mask = second_q ? (data_q >> (4'd8 - {1'b0, off_q})) : (data_q << off_q);
    page_mask = (page_q == PageMax) ? LastMask : 8'hFF;
    unique case (op_q)
      OP_CLR:  new_byte = mem_rdata_i & ~rect_mask;
      OP_SET:  new_byte = mem_rdata_i | rect_mask;
      OP_FLIP: new_byte = mem_rdata_i ^ rect_mask;
      OP_OR:   new_byte = mem_rdata_i | or_mask;
      OP_REPL: new_byte = data_q;
      default: new_byte = mem_rdata_i;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    col_d        = col_q;
    col_first_d  = col_first_q;
    col_last_d   = col_last_q;
    page_d       = page_q;
    page_first_d = page_first_q;
    page_last_d  = page_last_q;
    off_d        = off_q;
    lrow_d       = lrow_q;
    data_d       = data_q;
    rd_d         = rd_q;
    second_d     = second_q;
    in_ready_o   = 1'b0;
    mem_we_o     = 1'b0;
    mem_addr_o   = {page_q, col_q};
    mem_wdata_o  = new_byte & page_mask;
    done_byte    = 1'b1;
    res_o.valid  = 1'b0;
    res_o.rvalid = (op_q == OP_READ);
    res_o.data   = (op_q == OP_READ) ? ((state_q == ST_MODIFY) ? mem_rdata_i : rd_q) : 8'd0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = clr_q;
        mem_wdata_o = 8'd0;
        clr_d       = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_addr_o = {PW'(in_row[7:3]), in_col};
        if (in_valid_i) begin
          op_d         = in_op;
          col_d        = in_col;
          col_first_d  = in_col;
          col_last_d   = (sum_c >= ColLim) ? CW'(COLUMNS - 1) : sum_c[CW-1:0];
          page_d       = PW'(in_row[7:3]);
          page_first_d = PW'(in_row[7:3]);
          page_last_d  = PW'(last_row[7:3]);
          off_d        = in_row[2:0];
          lrow_d       = last_row[2:0];
          data_d       = data_i;
          second_d     = 1'b0;
          state_d      = (in_op == OP_NONE) ? ST_DONE : ST_MODIFY;
        end
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        mem_we_o = (op_q != OP_READ);
        rd_d     = mem_rdata_i;
        if ((op_q == OP_CLR) || (op_q == OP_SET) || (op_q == OP_FLIP)) begin
          if (col_q != col_last_q) begin
            col_d     = col_q + CW'(1);
            done_byte = 1'b0;
          end else if (page_q != page_last_q) begin
            col_d     = col_first_q;
            page_d    = page_q + PW'(1);
            done_byte = 1'b0;
          end
        end else if ((op_q == OP_OR) && !second_q && (page_q != PageMax)) begin
          second_d  = 1'b1;
          page_d    = page_q + PW'(1);
          done_byte = 1'b0;
        end
        if (!done_byte) begin
          state_d = ST_READ;
        end else if (res_ready_i) begin
          res_o.valid = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          res_o.valid = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    col_q        <= col_d;
    col_first_q  <= col_first_d;
    col_last_q   <= col_last_d;
    page_q       <= page_d;
    page_first_q <= page_first_d;
    page_last_q  <= page_last_d;
    off_q        <= off_d;
    lrow_q       <= lrow_d;
    data_q       <= data_d;
    rd_q         <= rd_d;
    second_q     <= second_d;
  end

  a_write_only_when_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == ST_CLEAR) || (state_q == ST_MODIFY))
    else $error("Frame store written outside clear or modify.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("New request taken while one is in progress.");

  a_column_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MODIFY) && ((op_q == OP_CLR) || (op_q == OP_SET) || (op_q == OP_FLIP)))
    |-> (col_q >= col_first_q) && (col_q <= col_last_q) && (page_q <= page_last_q))
    else $error("Rectangle walk left its span.");

  a_result_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_ready_i)
    else $error("Result issued while output register is full.");

endmodule

/* rtl/page_framebuffer_draw_engine.sv */
// Page framebuffer draw engine: each store byte a request touches is read and, but for
// read_byte, written back; the result is registered when the last byte is done and the next
// request is taken only after that (one byte for single-byte codes, none for unknown codes, two
// for an unaligned write_byte that spills into the next page). A stalled result holds off the input.
// After reset the store is cleared one byte per cycle, all 2^(CW+PW) bytes (1024 by default).
// Depends on pfde_pkg, pfde_ctrl and pfde_ram.
module page_framebuffer_draw_engine #(
  parameter int COLUMNS = pfde_pkg::COLUMNS_DEF,
  parameter int ROWS    = pfde_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] width_i,
  input  logic [7:0] height_i,
  input  logic       color_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       read_valid_o
);
  import pfde_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int PAGES = (ROWS + 7) / 8;
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = CW + PW;
  localparam int DEPTH = 1 << AW;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  res_t          res;
  logic          res_ready;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    read_data_q;
  logic          read_valid_q;

  assign res_ready = !out_valid_q || out_ready_i;

  pfde_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .CW     (CW),
    .PAGES  (PAGES),
    .PW     (PW),
    .AW     (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .x_i        (x_i),
    .y_i        (y_i),
    .width_i    (width_i),
    .height_i   (height_i),
    .color_i    (color_i),
    .data_i     (data_i),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  pfde_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      read_data_q  <= res.data;
      read_valid_q <= res.rvalid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign read_valid_o = read_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !res.valid)
    else $error("Pending result overwritten.");

  a_read_flag_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res.rvalid) |-> (res.data == 8'd0))
    else $error("Non-read result carries data.");

  a_output_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(read_data_q))
    else $error("Stalled result changed.");

endmodule
